### design/rwnp_pkg.sv
// Package: payload types, command and status codes for the neighbor picker.
package rwnp_pkg;

    localparam int MaxNeighborsDefault = 16;

    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_SET   = 2'd1;
    localparam logic [1:0] CMD_PICK  = 2'd2;
    localparam logic [1:0] CMD_QUERY = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_DUP    = 2'd1;
    localparam logic [1:0] ST_ABSENT = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] neighbor_id;
        logic [31:0] rate;
        logic [31:0] random_fraction;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] picked_id;
        logic [31:0] rate_out;
        logic [16:0] probability;
        logic [31:0] escape_time;
    } out_item_t;

endpackage

### design/rwnp_ram.sv
// Generic single-port-write, one-read RAM with registered read data.
module rwnp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### design/rwnp_div.sv
// Restoring divider, one quotient bit per cycle: quo = num / den.
module rwnp_div #(
    parameter int NW = 49,
    parameter int DW = 36
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [NW-1:0] quo
);

    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] quo_reg, quo_next;
    logic [DW:0]   rem_reg, rem_next;
    logic [DW-1:0] den_reg, den_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [DW:0]   trial;

    assign done = done_reg;
    assign quo  = quo_reg;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[DW-1:0], quo_reg[NW-1]};
        if (start)
        begin
            quo_next  = num;
            rem_next  = '0;
            den_next  = den;
            cnt_next  = CW'(NW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = trial - {1'b0, den_reg};
                quo_next = {quo_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

endmodule

### design/rate_weighted_neighbor_picker.sv
// Top level: sorted neighbor table in RAM, roulette-wheel pick, escape time.
// Sequence: a command walks the table one entry at a time (S_WALK reads, S_CHECK
// compares), an insert moves entries up one at a time (S_SHIFT, S_SHWR), then the
// 1/sum divide runs (query: a probability divide runs first when the neighbor is found).
// Throughput: one item at a time; next accepted once the result is taken.
// Reset: entry count, rate sum, escape time cleared; table RAM is not cleared.
module rate_weighted_neighbor_picker #(
    parameter int MAX_NEIGHBORS = rwnp_pkg::MaxNeighborsDefault
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  rwnp_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output rwnp_pkg::out_item_t out_data
);

    localparam int AW = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
    localparam int CW = $clog2(MAX_NEIGHBORS + 1);
    localparam int SW = 32 + CW;
    localparam int NW = 49;   // 2^48 numerator fits both divides

    // one-hot sequencer
    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_WALK   = 10'b00_0000_0010,  // read entry i, compare next cycle
        S_CHECK  = 10'b00_0000_0100,
        S_SHIFT  = 10'b00_0000_1000,  // move entry k-1 up to k
        S_SHWR   = 10'b00_0001_0000,
        S_WRITE  = 10'b00_0010_0000,
        S_PDIV   = 10'b00_0100_0000,
        S_EDIV   = 10'b00_1000_0000,
        S_WAITD  = 10'b01_0000_0000,
        S_OUT    = 10'b10_0000_0000
    } state_t;

    state_t              state_reg, state_next;
    rwnp_pkg::in_item_t  item_reg, item_next;
    rwnp_pkg::out_item_t res_reg, res_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [SW-1:0]       sum_reg, sum_next;
    logic [31:0]         esc_reg, esc_next;
    logic [CW-1:0]       idx_reg, idx_next;
    logic [SW-1:0]       cum_reg, cum_next;
    logic [SW-1:0]       thr_reg, thr_next;
    logic                pdiv_reg, pdiv_next;

    // RAM ports
    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [15:0]   wid, rid;
    logic [31:0]   wrate, rrate;

    rwnp_ram #(.WIDTH(16), .DEPTH(MAX_NEIGHBORS)) u_ids (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wid), .raddr(raddr), .rdata(rid)
    );
    rwnp_ram #(.WIDTH(32), .DEPTH(MAX_NEIGHBORS)) u_rates (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wrate), .raddr(raddr), .rdata(rrate)
    );

    // divider
    logic          div_start, div_done;
    logic [NW-1:0] div_num, div_quo;
    logic [SW-1:0] div_den;

    rwnp_div #(.NW(NW), .DW(SW)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num),
        .den(div_den), .done(div_done), .quo(div_quo)
    );

    // threshold multiply: frac * sum >> 32, split into a 32x32 low half and a 32xCW high half
    logic [63:0] thr_lo_prod;
    logic [63:0] thr_hi_prod;
    logic [SW:0] sum_upd;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign out_data  = res_reg;

    always_comb
    begin
        state_next = state_reg;
        item_next  = item_reg;
        res_next   = res_reg;
        count_next = count_reg;
        sum_next   = sum_reg;
        esc_next   = esc_reg;
        idx_next   = idx_reg;
        cum_next   = cum_reg;
        thr_next   = thr_reg;
        pdiv_next  = pdiv_reg;
        we         = 1'b0;
        waddr      = idx_reg[AW-1:0];
        raddr      = idx_reg[AW-1:0];
        wid        = item_reg.neighbor_id;
        wrate      = item_reg.rate;
        div_start  = 1'b0;
        div_num    = {1'b1, 48'd0} >> 16;   // 2^32 for escape time
        div_den    = sum_reg;
        thr_lo_prod = 64'(item_reg.random_fraction) * 64'(sum_reg[31:0]);
        thr_hi_prod = 64'(item_reg.random_fraction) * 64'(sum_reg[SW-1:32]);
        sum_upd    = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    item_next = in_data;
                    res_next  = '0;
                    idx_next  = '0;
                    cum_next  = '0;
                    pdiv_next = 1'b0;
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                // threshold computed on first walk cycle (idx 0)
                if (idx_reg == '0)
                begin
                    thr_next = SW'(thr_hi_prod + (thr_lo_prod >> 32));
                end
                if (idx_reg >= count_reg)
                begin
                    // end of table, nothing matched
                    case (item_reg.cmd)
                        rwnp_pkg::CMD_PICK, rwnp_pkg::CMD_QUERY:
                        begin
                            res_next.status = rwnp_pkg::ST_ABSENT;
                            state_next = S_EDIV;
                        end
                        default:
                        begin
                            if (count_reg >= CW'(MAX_NEIGHBORS))
                            begin
                                res_next.status = rwnp_pkg::ST_FULL;
                                state_next = S_EDIV;
                            end
                            else
                            begin
                                state_next = S_WRITE;
                            end
                        end
                    endcase
                end
                else
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                state_next = S_WALK;
                idx_next   = idx_reg + 1'b1;
                if (item_reg.cmd == rwnp_pkg::CMD_PICK)
                begin
                    cum_next = cum_reg + SW'(rrate);
                    if (cum_next > thr_reg)
                    begin
                        res_next.picked_id = rid;
                        state_next = S_EDIV;
                        idx_next   = idx_reg;
                    end
                end
                else if (rid == item_reg.neighbor_id)
                begin
                    idx_next = idx_reg;
                    case (item_reg.cmd)
                        rwnp_pkg::CMD_ADD:
                        begin
                            res_next.status = rwnp_pkg::ST_DUP;
                            state_next = S_EDIV;
                        end
                        rwnp_pkg::CMD_SET:
                        begin
                            we = 1'b1;
                            sum_upd  = {1'b0, sum_reg} - (SW+1)'(rrate)
                                       + (SW+1)'(item_reg.rate);
                            sum_next = sum_upd[SW-1:0];
                            state_next = S_EDIV;
                        end
                        default:
                        begin
                            res_next.rate_out = rrate;
                            if (sum_reg != '0)
                            begin
                                pdiv_next = 1'b1;
                                state_next = S_PDIV;
                            end
                            else
                            begin
                                state_next = S_EDIV;
                            end
                        end
                    endcase
                end
                else if (rid > item_reg.neighbor_id)
                begin
                    idx_next = idx_reg;
                    case (item_reg.cmd)
                        rwnp_pkg::CMD_QUERY:
                        begin
                            res_next.status = rwnp_pkg::ST_ABSENT;
                            state_next = S_EDIV;
                        end
                        default:
                        begin
                            if (count_reg >= CW'(MAX_NEIGHBORS))
                            begin
                                res_next.status = rwnp_pkg::ST_FULL;
                                state_next = S_EDIV;
                            end
                            else
                            begin
                                // shift from the top down; cum_reg holds k
                                cum_next   = SW'(count_reg);
                                state_next = S_SHIFT;
                            end
                        end
                    endcase
                end
            end
            S_SHIFT:
            begin
                if (cum_reg[CW-1:0] == idx_reg)
                begin
                    state_next = S_WRITE;
                end
                else
                begin
                    raddr = AW'(cum_reg[CW-1:0] - 1'b1);
                    state_next = S_SHWR;
                end
            end
            S_SHWR:
            begin
                we    = 1'b1;
                waddr = cum_reg[AW-1:0];
                wid   = rid;
                wrate = rrate;
                cum_next = cum_reg - 1'b1;
                state_next = S_SHIFT;
            end
            S_WRITE:
            begin
                we = 1'b1;
                count_next = count_reg + 1'b1;
                sum_next   = sum_reg + SW'(item_reg.rate);
                state_next = S_EDIV;
            end
            S_PDIV:
            begin
                div_start = 1'b1;
                div_num   = NW'({res_next.rate_out, 16'd0});
                state_next = S_WAITD;
            end
            S_EDIV:
            begin
                if (res_reg.status != rwnp_pkg::ST_OK)
                begin
                    res_next.picked_id = '0;
                end
                if (sum_reg == '0)
                begin
                    esc_next = '0;
                    res_next.escape_time = '0;
                    state_next = S_OUT;
                end
                else if (sum_reg == SW'(1))
                begin
                    esc_next = '1;
                    res_next.escape_time = '1;
                    state_next = S_OUT;
                end
                else
                begin
                    div_start = 1'b1;
                    state_next = S_WAITD;
                end
            end
            S_WAITD:
            begin
                if (div_done)
                begin
                    if (pdiv_reg)
                    begin
                        pdiv_next = 1'b0;
                        res_next.probability = (div_quo > NW'(65536)) ?
                                               17'd65536 : div_quo[16:0];
                        state_next = S_EDIV;
                    end
                    else
                    begin
                        esc_next = div_quo[31:0];
                        res_next.escape_time = div_quo[31:0];
                        state_next = S_OUT;
                    end
                end
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            sum_reg   <= '0;
            esc_reg   <= '0;
            pdiv_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
            esc_reg   <= esc_next;
            pdiv_reg  <= pdiv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        res_reg  <= res_next;
        idx_reg  <= idx_next;
        cum_reg  <= cum_next;
        thr_reg  <= thr_next;
    end

endmodule
